// ===== hdl/single_source_shortest_path_top_macros.svh =====
// assertion macros used by the datapath
`ifndef SINGLE_SOURCE_SHORTEST_PATH_TOP_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// cond must never hold outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: condition must never hold");
// ante implies cons in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(lbl, cond)
`define ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

// ===== hdl/ssp_pkg.sv =====
package ssp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;

  localparam int VIDX_W     = $clog2(MAX_VERTICES);
  localparam int ADDR_W     = 2 * VIDX_W;
  localparam int RAM_DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int DIST_W     = WEIGHT_BITS + VIDX_W + 1;

  // fixed field widths
  localparam int VCOUNT_W   = 5;
  localparam int SRC_W      = 4;
  localparam int ROW_W      = 4;
  localparam int IN_WT_W    = 16;
  localparam int OUT_DIST_W = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
    logic [IN_WT_W-1:0] weight;
  } ssp_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]      vertex;
    logic [OUT_DIST_W-1:0] distance;
    logic                  reachable;
    logic                  last;
  } ssp_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SEL,
    ST_RELAX,
    ST_DRAIN,
    ST_EMIT
  } ssp_state_t;

  typedef struct packed {
    logic clr_wr;
    logic edge_wr;
    logic run_init;
    logic scan_step;
    logic sel;
    logic relax_step;
    logic round_next;
    logic emit_step;
  } ssp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_last;
    logic round_last;
    logic pick_known;
  } ssp_sts_t;

endpackage

// ===== hdl/ssp_ram.sv =====
module ssp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// ===== hdl/ssp_datapath.sv =====
`include "single_source_shortest_path_top_macros.svh"

module ssp_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ssp_pkg::ssp_cmd_t               cmd_i,
  output ssp_pkg::ssp_sts_t               sts_o,
  input  ssp_pkg::ssp_in_t                in_data,
  input  logic                            cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_valid,
  output ssp_pkg::ssp_out_t               out_data
);

  import ssp_pkg::*;

  logic [VCOUNT_W-1:0]    vertex_count_r;
  logic [SRC_W-1:0]       source_vertex_r;
  logic [VCOUNT_W-1:0]    n_r;
  logic [VCOUNT_W-1:0]    n_nxt;
  logic [VIDX_W-1:0]      n_m1;
  logic [VIDX_W-1:0]      cnt_r;
  logic [VIDX_W-1:0]      round_r;
  logic [ADDR_W-1:0]      clr_cnt_r;
  logic [MAX_VERTICES-1:0] known_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [DIST_W-1:0]      dist_r [MAX_VERTICES];
  logic                   have_r;
  logic [VIDX_W-1:0]      pick_r;
  logic                   pick_known_r;
  logic [DIST_W-1:0]      pick_dist_r;
  logic                   rlx_vld_r;
  logic [VIDX_W-1:0]      rlx_v_r;
  logic                   out_valid_r;
  ssp_out_t               out_data_r;

  logic [VIDX_W-1:0]      rd_idx;
  logic [DIST_W-1:0]      rd_dist;
  logic                   rd_known;
  logic                   take;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic [DIST_W-1:0]      cand;
  logic                   dist_we;
  logic [VIDX_W-1:0]      src_idx;
  logic                   src_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r  <= VCOUNT_W'(MAX_VERTICES);
      source_vertex_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_VERTEX_COUNT:  vertex_count_r  <= cfg_wdata[VCOUNT_W-1:0];
        REG_SOURCE_VERTEX: source_vertex_r <= cfg_wdata[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // vertex count saturated into one..max
  always_comb begin
    if (vertex_count_r == '0) begin
      n_nxt = VCOUNT_W'(1);
    end else if (vertex_count_r > VCOUNT_W'(MAX_VERTICES)) begin
      n_nxt = VCOUNT_W'(MAX_VERTICES);
    end else begin
      n_nxt = vertex_count_r;
    end
  end

  assign src_idx = VIDX_W'(source_vertex_r);
  assign src_ok  = VCOUNT_W'(source_vertex_r) < n_nxt;
  assign n_m1    = VIDX_W'(n_r - VCOUNT_W'(1));

  // one shared read index into the distance registers
  assign rd_idx   = rlx_vld_r ? rlx_v_r : cnt_r;
  assign rd_dist  = dist_r[rd_idx];
  assign rd_known = known_r[rd_idx];

  // ties go to the higher index, unreached vertices still qualify
  always_comb begin
    if (visited_r[cnt_r]) begin
      take = 1'b0;
    end else if (!have_r) begin
      take = 1'b1;
    end else if (rd_known) begin
      take = !pick_known_r || (rd_dist <= pick_dist_r);
    end else begin
      take = !pick_known_r;
    end
  end

  // relaxation of the row entry read in the previous cycle
  assign cand    = pick_dist_r + DIST_W'(ram_rdata);
  assign dist_we = rlx_vld_r && !visited_r[rlx_v_r] && (ram_rdata != '0) &&
                   (!known_r[rlx_v_r] || (cand < rd_dist));

  // weight store write port: clearing sweep or edge write
  always_comb begin
    ram_we    = cmd_i.clr_wr || cmd_i.edge_wr;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    if (cmd_i.edge_wr) begin
      ram_waddr = {VIDX_W'(in_data.row), VIDX_W'(in_data.col)};
      ram_wdata = WEIGHT_BITS'(in_data.weight);
    end
  end

  ssp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_weights (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   ({pick_r, cnt_r}),
    .rdata_r (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= VCOUNT_W'(MAX_VERTICES);
      cnt_r        <= '0;
      round_r      <= '0;
      clr_cnt_r    <= '0;
      known_r      <= '0;
      visited_r    <= '0;
      have_r       <= 1'b0;
      pick_known_r <= 1'b0;
      rlx_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rlx_vld_r   <= cmd_i.relax_step;
      out_valid_r <= cmd_i.emit_step;
      if (cmd_i.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd_i.run_init) begin
        cnt_r <= '0;
      end else if (cmd_i.scan_step || cmd_i.relax_step || cmd_i.emit_step) begin
        cnt_r <= sts_o.cnt_last ? '0 : cnt_r + VIDX_W'(1);
      end
      if (cmd_i.run_init) begin
        n_r       <= n_nxt;
        round_r   <= '0;
        visited_r <= '0;
        known_r   <= src_ok ? (MAX_VERTICES'(1) << src_idx) : '0;
        have_r    <= 1'b0;
      end
      if (cmd_i.round_next) begin
        round_r <= round_r + VIDX_W'(1);
        have_r  <= 1'b0;
      end
      if (cmd_i.scan_step && take) begin
        have_r       <= 1'b1;
        pick_known_r <= rd_known;
      end
      if (cmd_i.sel) begin
        visited_r[pick_r] <= 1'b1;
      end
      if (dist_we) begin
        known_r[rlx_v_r] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.run_init && src_ok) begin
      dist_r[src_idx] <= '0;
    end
    if (dist_we) begin
      dist_r[rlx_v_r] <= cand;
    end
    if (cmd_i.scan_step && take) begin
      pick_r      <= cnt_r;
      pick_dist_r <= rd_dist;
    end
    rlx_v_r <= cnt_r;
    if (cmd_i.emit_step) begin
      out_data_r.vertex    <= ROW_W'(cnt_r);
      out_data_r.distance  <= rd_known ? OUT_DIST_W'(rd_dist) : '0;
      out_data_r.reachable <= rd_known;
      out_data_r.last      <= sts_o.cnt_last;
    end
  end

  assign sts_o.clr_last   = (clr_cnt_r == ADDR_W'(RAM_DEPTH - 1));
  assign sts_o.cnt_last   = (cnt_r == n_m1);
  assign sts_o.round_last = (round_r == n_m1);
  assign sts_o.pick_known = pick_known_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_relax_hits_visited, dist_we && visited_r[rlx_v_r])
  `ASSERT_IMPLY(a_pick_unvisited, cmd_i.sel, have_r && !visited_r[pick_r])
  `ASSERT_IMPLY(a_out_in_range, out_valid_r, VIDX_W'(out_data_r.vertex) <= n_m1)
  `ASSERT_NEVER(a_visited_count, $countones(visited_r) > int'(n_r))

endmodule

// ===== hdl/ssp_ctrl.sv =====
module ssp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               func,
  input  ssp_pkg::ssp_sts_t  sts_i,
  output ssp_pkg::ssp_cmd_t  cmd_o,
  output logic               busy
);

  import ssp_pkg::*;

  ssp_state_t state_r;
  ssp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts_i.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start && (func == FUNC_RUN)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN:  if (sts_i.cnt_last) state_nxt = ST_SEL;
      ST_SEL: begin
        if (sts_i.pick_known) begin
          state_nxt = ST_RELAX;
        end else if (sts_i.round_last) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_RELAX: if (sts_i.cnt_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = sts_i.round_last ? ST_EMIT : ST_SCAN;
      ST_EMIT:  if (sts_i.cnt_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_r)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        cmd_o.run_init = start && (func == FUNC_RUN);
        cmd_o.edge_wr  = start && (func == FUNC_WRITE);
      end
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_SEL: begin
        cmd_o.sel        = 1'b1;
        cmd_o.round_next = !sts_i.pick_known && !sts_i.round_last;
      end
      ST_RELAX: cmd_o.relax_step = 1'b1;
      // last relaxed entry settles here
      ST_DRAIN: cmd_o.round_next = !sts_i.round_last;
      ST_EMIT:  cmd_o.emit_step = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== hdl/single_source_shortest_path_top.sv =====
// weight write: taken at start, no result
// run with n vertices: n rounds of scan, select, relax and settle, where relax and settle
// are skipped for an unreached pick; then one result per vertex
// the scan of the distance registers and the row read of the weight memory set the rate
// results leave one per cycle with a strobe; the receiver cannot stall
// after reset every entry of the weight memory is swept to zero with busy high
module single_source_shortest_path_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ssp_pkg::ssp_in_t                in_data,
  output logic                            out_valid,
  output ssp_pkg::ssp_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import ssp_pkg::*;

  ssp_cmd_t cmd;
  ssp_sts_t sts;

  ssp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy  (busy)
  );

  ssp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
